/* rtl/core/rc_pkg.sv */
// ----------------------------------------------------------------------------
// rc_pkg: shared types and constants of the radix converter
// Register indexes, ASCII codes, base limits, FSM states and the divider
// control and status structs.
// ----------------------------------------------------------------------------
package rc_pkg;

  localparam int unsigned BASE_W  = 5;  // width of a base register
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned REM_W   = 4;  // a remainder is below 16

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BASE = 1'b1;

  localparam logic [BASE_W-1:0] BASE_MIN        = 5'd2;
  localparam logic [BASE_W-1:0] BASE_MAX        = 5'd16;
  localparam logic [BASE_W-1:0] SOURCE_BASE_RST = 5'd10;
  localparam logic [BASE_W-1:0] TARGET_BASE_RST = 5'd16;

  localparam logic [7:0] ASCII_0     = 8'h30;
  localparam logic [7:0] ASCII_9     = 8'h39;
  localparam logic [7:0] ASCII_UA    = 8'h41;
  localparam logic [7:0] ASCII_LA    = 8'h61;
  localparam logic [7:0] ASCII_LZ    = 8'h7a;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] LETTER_BASE = 8'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD,
    ST_OUT
  } rc_state_e;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // digit value 0..15 to ASCII '0'-'9' / 'A'-'F'
  function automatic logic [6:0] ascii_of(input logic [REM_W-1:0] d);
    logic [7:0] c;
    if (d < REM_W'(LETTER_BASE)) begin
      c = ASCII_0 + 8'(d);
    end else begin
      c = ASCII_UA + 8'(d) - LETTER_BASE;
    end
    return c[6:0];
  endfunction

endpackage

/* rtl/core/radix_converter.sv */
// ----------------------------------------------------------------------------
// radix_converter: ASCII digit string conversion between bases 2..16
// Accumulates incoming digits in the source base and emits the value as
// ASCII digits in the target base, most significant first.
// ----------------------------------------------------------------------------
// A number arrives as ASCII digit beats, most significant first, in
// source_base; tlast marks its final digit. With each accepted beat
// the accumulator becomes value * source_base + digit, wrapping at
// VALUE_WIDTH bits. '0'-'9' are worth their digit, any other code is
// upper-cased (for 'a'-'z') and worth code - 'A' + 10, with no range check.
// On the tlast beat the value is split into target_base digits by a
// bit-serial divider, one full division per digit. Remainders
// go to a small memory, at most MAX_DIGITS of them (the least significant
// ones when the value needs more). The digits then leave most significant
// first, each read from the memory before it is offered, and tlast flags the
// least significant one; zero gives a single '0'. No input is taken from
// the tlast beat until the last output beat is taken. Base writes outside
// 2..16 and writes to unknown indexes are dropped; write only while idle.
// ----------------------------------------------------------------------------
module radix_converter
  import rc_pkg::*;
#(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_DIGITS  = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [BASE_W-1:0]    cfg_data_i,
  // input digits
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [7:0]           s_axis_tdata,   // [7:0] digit_char
  input  logic                 s_axis_tlast,   // last_digit
  // output digits
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [7:0]           m_axis_tdata,   // [6:0] out_char, [7] zero
  output logic                 m_axis_tlast    // out_last
);

  localparam int unsigned CNT_W = $clog2(MAX_DIGITS + 1);
  localparam int unsigned IDX_W = $clog2(MAX_DIGITS);

  rc_state_e               state_q, state_d;
  logic [BASE_W-1:0]       src_base_q, tgt_base_q;
  logic [VALUE_WIDTH-1:0]  acc_q, acc_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;

  logic [VALUE_WIDTH-1:0]  acc_next;
  logic [VALUE_WIDTH-1:0]  worth;
  logic [7:0]              ch;
  logic                    in_beat;

  div_ctrl_t               div_ctrl;
  div_stat_t               div_stat;
  logic [VALUE_WIDTH-1:0]  div_dividend;
  logic [VALUE_WIDTH-1:0]  div_quot;
  logic [REM_W-1:0]        div_rem;

  logic                    st_we, st_re;
  logic [IDX_W-1:0]        st_raddr;
  logic [REM_W-1:0]        st_rdata;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_base_q <= SOURCE_BASE_RST;
      tgt_base_q <= TARGET_BASE_RST;
    end else if (cfg_we_i && cfg_data_i >= BASE_MIN && cfg_data_i <= BASE_MAX) begin
      unique case (cfg_idx_i)
        REG_SOURCE_BASE: src_base_q <= cfg_data_i;
        REG_TARGET_BASE: tgt_base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // digit value and accumulate (narrow base times value)
  // --------------------------------------------------------------------------
  always_comb begin
    ch = s_axis_tdata;
    if (ch >= ASCII_0 && ch <= ASCII_9) begin
      worth = VALUE_WIDTH'(ch - ASCII_0);
    end else begin
      if (ch >= ASCII_LA && ch <= ASCII_LZ) begin
        ch = ch - CASE_OFFSET;
      end
      // non-digits wrap modulo 2^VALUE_WIDTH
      worth = VALUE_WIDTH'(ch) - VALUE_WIDTH'(ASCII_UA) + VALUE_WIDTH'(LETTER_BASE);
    end
    acc_next = acc_q * VALUE_WIDTH'(src_base_q) + worth;
  end

  assign in_beat = s_axis_tvalid && s_axis_tready;

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d        = state_q;
    acc_d          = acc_q;
    cnt_d          = cnt_q;
    div_ctrl.start = 1'b0;
    div_dividend   = acc_next;
    st_we          = 1'b0;
    st_re          = 1'b0;
    st_raddr       = IDX_W'(cnt_q - 1'b1);
    s_axis_tready  = 1'b0;
    m_axis_tvalid  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (in_beat) begin
          if (s_axis_tlast) begin
            acc_d          = '0;
            cnt_d          = '0;
            div_ctrl.start = 1'b1;
            state_d        = ST_DIV;
          end else begin
            acc_d = acc_next;
          end
        end
      end
      ST_DIV: begin
        div_dividend = div_quot;
        if (div_stat.done) begin
          st_we = 1'b1;
          cnt_d = cnt_q + 1'b1;
          // keep dividing while digits remain and the store has room
          if (div_quot != '0 && cnt_q < CNT_W'(MAX_DIGITS - 1)) begin
            div_ctrl.start = 1'b1;
          end else begin
            state_d = ST_RD;
          end
        end
      end
      ST_RD: begin
        st_re   = 1'b1;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          cnt_d   = cnt_q - 1'b1;
          state_d = (cnt_q == CNT_W'(1)) ? ST_IDLE : ST_RD;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
    end
  end

  assign m_axis_tdata = {1'b0, ascii_of(st_rdata)};
  assign m_axis_tlast = (cnt_q == CNT_W'(1));

  // --------------------------------------------------------------------------
  // datapath units
  // --------------------------------------------------------------------------
  rc_serial_div #(
    .WIDTH (VALUE_WIDTH)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (div_ctrl),
    .dividend_i  (div_dividend),
    .divisor_i   (tgt_base_q),
    .stat_o      (div_stat),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  rc_digit_store #(
    .DEPTH (MAX_DIGITS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (cnt_q[IDX_W-1:0]),
    .wdata_i (div_rem),
    .re_i    (st_re),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while emitting");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond store depth");

  a_out_has_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_OUT || state_q == ST_RD) |-> cnt_q != '0)
    else $error("emission with empty store");

  a_div_only_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_stat.busy |-> state_q == ST_DIV)
    else $error("divider running outside conversion");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ((m_axis_tdata >= {1'b0, ASCII_0[6:0]} &&
                        m_axis_tdata <= {1'b0, ASCII_9[6:0]}) ||
                       (m_axis_tdata >= {1'b0, ASCII_UA[6:0]} &&
                        m_axis_tdata <= 8'h46)))
    else $error("output character out of range");

endmodule

/* rtl/core/rc_serial_div.sv */
// ----------------------------------------------------------------------------
// rc_serial_div: bit-serial restoring divider
// Divides a WIDTH-bit value by a base of 2..16, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rc_serial_div
  import rc_pkg::*;
#(
  parameter int unsigned WIDTH = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  div_ctrl_t           ctrl_i,
  input  logic [WIDTH-1:0]    dividend_i,
  input  logic [BASE_W-1:0]   divisor_i,
  output div_stat_t           stat_o,
  output logic [WIDTH-1:0]    quotient_o,
  output logic [REM_W-1:0]    remainder_o
);

  localparam int unsigned STEP_W = $clog2(WIDTH);

  logic [WIDTH-1:0]  q_q, q_d;
  logic [REM_W-1:0]  r_q, r_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [BASE_W-1:0] trial;

  always_comb begin
    q_d    = q_q;
    r_d    = r_q;
    step_d = step_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {r_q, q_q[WIDTH-1]};
    if (ctrl_i.start) begin
      q_d    = dividend_i;
      r_d    = '0;
      step_d = STEP_W'(WIDTH - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      // shift remainder left, subtract when the trial fits
      if (trial >= divisor_i) begin
        r_d = REM_W'(trial - divisor_i);
        q_d = {q_q[WIDTH-2:0], 1'b1};
      end else begin
        r_d = trial[REM_W-1:0];
        q_d = {q_q[WIDTH-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    r_q <= r_d;
  end

  assign stat_o.busy  = busy_q;
  assign stat_o.done  = done_q;
  assign quotient_o   = q_q;
  assign remainder_o  = r_q;

endmodule

/* rtl/core/rc_digit_store.sv */
// ----------------------------------------------------------------------------
// rc_digit_store: remainder scratch memory
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module rc_digit_store
  import rc_pkg::*;
#(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [REM_W-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [REM_W-1:0]         rdata_o
);

  logic [REM_W-1:0] mem [DEPTH];
  logic [REM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* verif/tb_radix_converter.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_radix_converter: self-checking testbench of the radix converter
// Streams ASCII digit strings into the block under varying base settings,
// predicts the emitted target-base digits beat by beat and compares every
// output beat against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tb_radix_converter;
  import rc_pkg::*;

  localparam int VALUE_W    = 32;
  localparam int DIGITS_MAX = 32;
  localparam int RANDOM_BEATS = 460;
  // settle time once nothing is pending; covers the accumulate step of a digit
  localparam int SETTLE = 8;
  // longest quiet stretch of a correct run: a full store of digits through
  // the divider plus the longest output stall; taken about four times over
  localparam int IDLE_LIMIT = 5000;

  // --------------------------------------------------------------------------
  // Scoreboard: mirror of the base registers and the accumulator, plus the
  // queue of digit beats still owed by the block.
  // --------------------------------------------------------------------------
  class conversion_scoreboard;
    typedef struct packed {
      logic [6:0] ch;
      logic       last;
    } digit_beat_t;

    logic [BASE_W-1:0]  src_base;
    logic [BASE_W-1:0]  tgt_base;
    logic [VALUE_W-1:0] value;
    digit_beat_t        digits_due[$];
    int unsigned        errors;

    function new();
      src_base = SOURCE_BASE_RST;
      tgt_base = TARGET_BASE_RST;
      value    = '0;
      errors   = 0;
    endfunction

    // out-of-range bases are dropped by the block
    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [BASE_W-1:0] val);
      if (val < BASE_MIN || val > BASE_MAX) return;
      if (idx == REG_SOURCE_BASE) src_base = val;
      else if (idx == REG_TARGET_BASE) tgt_base = val;
    endfunction

    // worth of one character; anything but '0'-'9' is letter-coded, no check
    function logic [VALUE_W-1:0] char_worth(logic [7:0] c);
      logic [7:0] u;
      u = c;
      if (c >= ASCII_0 && c <= ASCII_9) return {24'h0, c - ASCII_0};
      if (c >= ASCII_LA && c <= ASCII_LZ) u = c - CASE_OFFSET;
      return {24'h0, u} - {24'h0, ASCII_UA} + {24'h0, LETTER_BASE};
    endfunction

    function void note_digit(logic [7:0] c, logic l);
      logic [VALUE_W-1:0] v;
      logic [VALUE_W-1:0] r;
      logic [VALUE_W-1:0] t;
      logic [3:0]         rems[DIGITS_MAX];
      logic [7:0]         a;
      digit_beat_t        b;
      int                 n;
      value = value * {27'h0, src_base} + char_worth(c);
      if (!l) return;
      t = {27'h0, tgt_base};
      v = value;
      n = 0;
      do begin
        r = v % t;
        rems[n] = r[3:0];
        n++;
        v = v / t;
      end while (v != 0 && n < DIGITS_MAX);
      for (int k = n - 1; k >= 0; k--) begin
        if (rems[k] < 4'd10) a = ASCII_0 + {4'h0, rems[k]};
        else a = ASCII_UA + {4'h0, rems[k]} - LETTER_BASE;
        b.ch   = a[6:0];
        b.last = (k == 0);
        digits_due.push_back(b);
      end
      value = '0;
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_beat(logic [7:0] data, logic l);
      digit_beat_t e;
      if (digits_due.size() == 0) begin
        report($sformatf("output beat with nothing pending: tdata=%h tlast=%b", data, l));
        return;
      end
      e = digits_due.pop_front();
      if (data !== {1'b0, e.ch})
        report($sformatf("out_char: got tdata=%h, want %h", data, {1'b0, e.ch}));
      if (l !== e.last)
        report($sformatf("out_last: got %b, want %b (char %h)", l, e.last, e.ch));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // DUT signals
  // --------------------------------------------------------------------------
  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [BASE_W-1:0]    cfg_data_i;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata;   // [7:0] digit_char
  logic                 s_axis_tlast;   // last_digit
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [7:0]           m_axis_tdata;   // [6:0] out_char, [7] zero
  logic                 m_axis_tlast;   // out_last

  conversion_scoreboard sb;
  bit                   quiet;         // phase without idling on either side
  int                   beats_sent;
  int                   stall_left = 0;
  int                   idle_cycles = 0;

  radix_converter #(
    .VALUE_WIDTH (VALUE_W),
    .MAX_DIGITS  (DIGITS_MAX)
  ) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // 20 ns clock
  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // idle length: mostly none or short, now and then long
  function int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // register value: mostly legal, biased to the extremes, some illegal ones
  function logic [BASE_W-1:0] pick_base();
    int r;
    int v;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      v = $urandom_range(0, 16);
      return (v < 2) ? BASE_W'(v) : BASE_W'(v + 15);  // 0, 1 or 17..31
    end
    if (r < 40) return ($urandom_range(0, 1) != 0) ? BASE_MIN : BASE_MAX;
    return BASE_W'($urandom_range(2, 16));
  endfunction

  // --------------------------------------------------------------------------
  // Output side: random tready, changed at the falling edge only
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  // --------------------------------------------------------------------------
  // Monitor and watchdog, sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata, m_axis_tlast);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat accepted for %0d cycles", idle_cycles);
        $display("Verification failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side drivers; every task starts and ends at a falling edge
  // --------------------------------------------------------------------------
  task send_beat(input logic [7:0] c, input logic l);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= l;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_digit(c, l);
    beats_sent++;
    @(negedge clk_i);
  endtask

  // whole number from a string, tlast on its final character
  task send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], i == s.len() - 1);
  endtask

  // hold off until every pending digit is out, then let the block settle
  task drain();
    s_axis_tvalid <= 1'b0;
    while (sb.digits_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  // one write; we drops after each write so back-to-back writes never collide
  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [BASE_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    sb.write_reg(idx, val);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // mostly well-formed digits of the source base, some numbers laced with
  // arbitrary codes; lengths mostly short, a few long enough to wrap
  task send_random_number();
    int         len;
    int         r;
    int         d;
    bit         noisy;
    logic [7:0] c;
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(1, 8);
    else if (r < 92) len = $urandom_range(9, 14);
    else len = $urandom_range(15, 40);
    noisy = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < len; i++) begin
      if (noisy && $urandom_range(0, 2) == 0) begin
        c = 8'($urandom_range(0, 255));
      end else begin
        d = $urandom_range(0, int'(sb.src_base) - 1);
        if (d < 10) c = ASCII_0 + 8'(d);
        else c = (($urandom_range(0, 1) != 0) ? ASCII_UA : ASCII_LA) + 8'(d) - LETTER_BASE;
      end
      send_beat(c, i == len - 1);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = REG_SOURCE_BASE;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    quiet         = 1'b0;
    beats_sent    = 0;
    sb = new();
    // reset spans the opening rising edges, released at the falling edge after them
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset bases, decimal in, hex out
    send_text("0");             // zero value: single '0'
    send_text("zZ");            // letters above the radix, both cases
    send_beat(8'h00, 1'b1);     // below '0': negative worth wraps
    send_beat(8'hff, 1'b1);     // top code, taken unsigned
    send_beat(8'h80, 1'b1);
    drain();

    // binary both ways: widest output
    write_reg(REG_SOURCE_BASE, BASE_MIN);
    write_reg(REG_TARGET_BASE, BASE_MIN);
    send_text("1");
    send_beat(8'h00, 1'b1);     // 32 binary digits
    send_beat(8'h00, 1'b0);     // accumulator wraps
    send_beat(8'h00, 1'b1);
    drain();

    // illegal writes must leave both bases as they are
    write_reg(REG_SOURCE_BASE, 5'd0);
    write_reg(REG_SOURCE_BASE, 5'd1);
    write_reg(REG_SOURCE_BASE, 5'd17);
    write_reg(REG_SOURCE_BASE, 5'd31);
    write_reg(REG_TARGET_BASE, 5'd0);
    write_reg(REG_TARGET_BASE, 5'd1);
    write_reg(REG_TARGET_BASE, 5'd17);
    write_reg(REG_TARGET_BASE, 5'd31);
    send_text("1");
    drain();

    // hex in, decimal out: all-ones value
    write_reg(REG_SOURCE_BASE, BASE_MAX);
    write_reg(REG_TARGET_BASE, 5'd10);
    send_text("fFfFfFfF");
    drain();
    write_reg(REG_TARGET_BASE, BASE_MAX);
    send_text("aB");

    // random phases; each drain is also a sender hold-off until empty
    while (beats_sent < RANDOM_BEATS) begin
      drain();
      quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        if ($urandom_range(0, 1) != 0) begin
          write_reg(REG_SOURCE_BASE, pick_base());
          write_reg(REG_TARGET_BASE, pick_base());
        end else begin
          write_reg(REG_TARGET_BASE, pick_base());
          write_reg(REG_SOURCE_BASE, pick_base());
        end
      end
      repeat ($urandom_range(1, 5)) send_random_number();
    end

    quiet = 1'b0;
    drain();
    repeat (40) @(negedge clk_i);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* radix_converter.f */
rtl/core/rc_pkg.sv
rtl/core/rc_serial_div.sv
rtl/core/rc_digit_store.sv
rtl/core/radix_converter.sv
verif/tb_radix_converter.sv
